FILE: hw/rtl/css_pkg.sv
// Shared widths, latencies and types of the 3x3 Cramer solver.
package css_pkg;

    localparam int CW            = 16;          // coefficient width, Q8.8
    localparam int COEF_FRAC     = 8;
    localparam int SOL_FRAC_DEF  = 16;
    localparam int SOL_W         = 32;
    localparam int P2W           = 2 * CW;      // product of two coefficients
    localparam int P3W           = 3 * CW;      // product of three coefficients
    localparam int DET_W         = 3 * CW + 3;  // sum of six triple products
    localparam int QB            = SOL_W - 1;   // quotient magnitude bits
    localparam int DET_LAT       = 3;
    localparam int DIV_LAT       = QB + 2;
    localparam int RES_LAT       = 2;
    localparam int IN_W          = 12 * CW;
    localparam int OUT_W         = 6 * SOL_W;

    localparam logic [SOL_W-1:0] SOL_MAX = {1'b0, {(SOL_W-1){1'b1}}};
    localparam logic [SOL_W-1:0] SOL_MIN = {1'b1, {(SOL_W-1){1'b0}}};

    typedef logic [2:0][2:0][CW-1:0] t_mat;
    typedef logic [2:0][CW-1:0]      t_vec;
    typedef logic [2:0][SOL_W-1:0]   t_sol;

    typedef struct packed {
        t_mat a;
        t_vec b;
    } t_sys;

endpackage

FILE: hw/rtl/css_det.sv
// Three-stage pipelined 3x3 determinant by the rule of Sarrus.
module css_det (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  css_pkg::t_mat                     i_mat,
    output logic signed [css_pkg::DET_W-1:0]  o_det
);
    import css_pkg::*;

    logic signed [P2W-1:0]   r_pair [6];
    logic signed [CW-1:0]    r_fac  [6];
    logic signed [P3W-1:0]   r_term [6];
    logic signed [DET_W-1:0] r_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair[0] <= $signed(i_mat[1][1]) * $signed(i_mat[2][2]);
            r_fac[0]  <= $signed(i_mat[0][0]);
            r_pair[1] <= $signed(i_mat[0][1]) * $signed(i_mat[1][2]);
            r_fac[1]  <= $signed(i_mat[2][0]);
            r_pair[2] <= $signed(i_mat[2][1]) * $signed(i_mat[0][2]);
            r_fac[2]  <= $signed(i_mat[1][0]);
            r_pair[3] <= $signed(i_mat[1][1]) * $signed(i_mat[0][2]);
            r_fac[3]  <= $signed(i_mat[2][0]);
            r_pair[4] <= $signed(i_mat[2][1]) * $signed(i_mat[1][2]);
            r_fac[4]  <= $signed(i_mat[0][0]);
            r_pair[5] <= $signed(i_mat[0][1]) * $signed(i_mat[2][2]);
            r_fac[5]  <= $signed(i_mat[1][0]);
            for (int k = 0; k < 6; k++) begin
                r_term[k] <= r_pair[k] * r_fac[k];
            end
            r_det <= DET_W'(r_term[0]) + DET_W'(r_term[1]) + DET_W'(r_term[2])
                   - DET_W'(r_term[3]) - DET_W'(r_term[4]) - DET_W'(r_term[5]);
        end
    end

    assign o_det = r_det;

endmodule

FILE: hw/rtl/css_div.sv
// Pipelined restoring divider: (num / den) scaled to fixed point, saturated.
module css_div #(
    parameter int SOL_FRAC_BITS = css_pkg::SOL_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [css_pkg::DET_W-1:0]  i_num,
    input  logic signed [css_pkg::DET_W-1:0]  i_den,
    output logic [css_pkg::SOL_W-1:0]         o_quo
);
    import css_pkg::*;

    localparam int CWID = DET_W + QB;

    logic [DET_W-1:0] w_num_mag;
    logic [DET_W-1:0] w_den_mag;

    logic [CWID-1:0]  r_rem [0:QB-1];
    logic [DET_W-1:0] r_dsr [0:QB-1];
    logic [QB-1:0]    r_q   [0:QB];
    logic             r_neg [0:QB];
    logic             r_ovf [0:QB];
    logic [SOL_W-1:0] r_quo;

    always_comb begin
        w_num_mag = i_num[DET_W-1] ? DET_W'(-i_num) : DET_W'(i_num);
        w_den_mag = i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
    end

    // Setup: scale the numerator and flag a quotient that cannot fit.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CWID'(w_num_mag) << SOL_FRAC_BITS;
            r_dsr[0] <= w_den_mag;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[DET_W-1] ^ i_den[DET_W-1];
            r_ovf[0] <= CWID'(w_num_mag) >= (CWID'(w_den_mag) << (QB - SOL_FRAC_BITS));
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < QB; s++) begin : g_bit
        logic [CWID-1:0] w_sub;
        logic            w_ge;
        assign w_sub = CWID'(r_dsr[s]) << (QB - 1 - s);
        assign w_ge  = r_rem[s] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1]   <= w_ge ? (r_q[s] | (QB'(1) << (QB - 1 - s))) : r_q[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end

        if (s < QB - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= w_ge ? (r_rem[s] - w_sub) : r_rem[s];
                    r_dsr[s+1] <= r_dsr[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[QB]) begin
                r_quo <= r_neg[QB] ? SOL_MIN : SOL_MAX;
            end else begin
                r_quo <= r_neg[QB] ? (SOL_W'(0) - {1'b0, r_q[QB]}) : {1'b0, r_q[QB]};
            end
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: hw/rtl/css_res.sv
// Merge stage: residuals A*x - b, singular zeroing and result packing.
module css_res #(
    parameter int SOL_FRAC_BITS = css_pkg::SOL_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  css_pkg::t_sys                 i_sys,
    input  css_pkg::t_sol                 i_x,
    input  logic                          i_sing,
    output logic [css_pkg::OUT_W-1:0]     o_tdata,
    output logic                          o_sing
);
    import css_pkg::*;

    localparam int PW = CW + SOL_W;
    localparam int SW = PW + 3;

    logic signed [PW-1:0] r_prod [3][3];
    logic signed [SW-1:0] r_bsh  [3];
    t_sol                 r_x;
    logic                 r_sing;

    logic signed [SW-1:0] n_sum [3];
    logic signed [SW-1:0] n_flr [3];
    logic [SOL_W-1:0]     n_res [3];
    logic [OUT_W-1:0]     r_tdata;
    logic                 r_osing;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(i_sys.a[i][j]) * $signed(i_x[j]);
                end
                r_bsh[i] <= SW'($signed(i_sys.b[i])) <<< SOL_FRAC_BITS;
            end
            r_x    <= i_x;
            r_sing <= i_sing;
        end
    end

    // Floor to the solution format, then clamp to 32 bits.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = SW'(r_prod[i][0]) + SW'(r_prod[i][1]) + SW'(r_prod[i][2])
                     - r_bsh[i];
            n_flr[i] = n_sum[i] >>> COEF_FRAC;
            if (n_flr[i][SW-1:SOL_W-1] == '0 || n_flr[i][SW-1:SOL_W-1] == '1) begin
                n_res[i] = n_flr[i][SOL_W-1:0];
            end else begin
                n_res[i] = n_flr[i][SW-1] ? SOL_MIN : SOL_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_osing <= r_sing;
            for (int k = 0; k < 3; k++) begin
                r_tdata[k*SOL_W +: SOL_W]     <= r_sing ? '0 : r_x[k];
                r_tdata[(k+3)*SOL_W +: SOL_W] <= r_sing ? '0 : n_res[k];
            end
        end
    end

    assign o_tdata = r_tdata;
    assign o_sing  = r_osing;

endmodule

FILE: hw/rtl/cramer_solver_3x3.sv
// Top level of the pipelined 3x3 Cramer's-rule linear system solver.
//
// Solves A*x = b for one 3x3 system per beat. Coefficients and right-hand side
// are signed Q8.8; the unknowns come back as signed fixed point with
// SOL_FRAC_BITS fractional bits (Q16.16 by default), truncated toward zero and
// saturated, and the residuals A*x - b in the same format, floored and
// saturated. A zero main determinant raises the singular flag in tuser and
// zeroes all data. Four determinant lanes (A and the three column-replaced
// matrices) run side by side, three divider lanes form the unknowns, and a
// merge stage computes residuals. The pipeline takes one beat per clock while
// it is not stalled, and each result passes through 3 determinant stages,
// 33 divider stages (one per quotient bit plus setup and sign), 2 merge stages.
// The whole pipeline advances whenever the output register is empty or being
// taken, so the upstream ready is high when the output is empty or taken.
module cramer_solver_3x3 #(
    parameter int SOL_FRAC_BITS = css_pkg::SOL_FRAC_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // a11 a12 a13 a21 a22 a23 a31 a32 a33 rhs1 rhs2 rhs3, 16 bits each
    input  logic [css_pkg::IN_W-1:0]      i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // sol_x sol_y sol_z res_1 res_2 res_3, 32 bits each
    output logic [css_pkg::OUT_W-1:0]     o_m_tdata,
    // singular
    output logic                          o_m_tuser
);
    import css_pkg::*;

    localparam int PRE_LAT = DET_LAT + DIV_LAT;
    localparam int TOT_LAT = PRE_LAT + RES_LAT;

    logic                    w_en;
    t_sys                    w_sys;
    t_mat                    w_mat [4];
    logic signed [DET_W-1:0] w_det [4];
    t_sol                    w_x;

    logic [TOT_LAT-1:0]      r_vld;
    t_sys                    r_sys_dly  [0:PRE_LAT-1];
    logic                    r_sing_dly [0:DIV_LAT-1];

    // Advance when the output slot is free or being drained.
    assign w_en       = !r_vld[TOT_LAT-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[TOT_LAT-1];

    // Unpack the input beat.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_sys.a[i][j] = i_s_tdata[(i*3+j)*CW +: CW];
            end
            w_sys.b[i] = i_s_tdata[(9+i)*CW +: CW];
        end
    end

    // Lane 0 sees A; lane l replaces column l-1 with b.
    for (genvar l = 0; l < 4; l++) begin : g_det
        always_comb begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    w_mat[l][r][c] = (l != 0 && c == l - 1) ? w_sys.b[r] : w_sys.a[r][c];
                end
            end
        end

        css_det u_det (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_mat (w_mat[l]),
            .o_det (w_det[l])
        );
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        css_div #(
            .SOL_FRAC_BITS (SOL_FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_det[k+1]),
            .i_den (w_det[0]),
            .o_quo (w_x[k])
        );
    end

    // Valid pipeline; control only, so it is the only reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_s_tvalid};
        end
    end

    // Hold the system and the singular flag alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sys_dly[0]  <= w_sys;
            r_sing_dly[0] <= (w_det[0] == '0);
            for (int s = 1; s < PRE_LAT; s++) begin
                r_sys_dly[s] <= r_sys_dly[s-1];
            end
            for (int s = 1; s < DIV_LAT; s++) begin
                r_sing_dly[s] <= r_sing_dly[s-1];
            end
        end
    end

    css_res #(
        .SOL_FRAC_BITS (SOL_FRAC_BITS)
    ) u_res (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_sys   (r_sys_dly[PRE_LAT-1]),
        .i_x     (w_x),
        .i_sing  (r_sing_dly[DIV_LAT-1]),
        .o_tdata (o_m_tdata),
        .o_sing  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_sing_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("singular result carries nonzero data");

    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
`endif

endmodule
